// ===== src/mbsp_pkg.sv =====
package mbsp_pkg;

  localparam logic [7:0] REALTIME_MIN = 8'hF8;
  localparam logic [7:0] SYSEX_START  = 8'hF0;
  localparam logic [7:0] SYSEX_END    = 8'hF7;
  localparam logic [7:0] NO_STATUS    = 8'h00;

  // high nibble of a channel status byte
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CC       = 4'hB;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;
  localparam logic [3:0] TYPE_BEND     = 4'hE;
  localparam logic [3:0] TYPE_SYSTEM   = 4'hF;

  localparam logic [6:0] CC_PRESS_MIN  = 7'd64;

  localparam logic [1:0] LEN_ONE_DATA  = 2'd2;
  localparam logic [1:0] LEN_TWO_DATA  = 2'd3;

  typedef enum logic [1:0] {
    KIND_NOTE  = 2'd0,
    KIND_CC    = 2'd1,
    KIND_BEND  = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]  msg_status;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [1:0]  msg_length;
    logic [3:0]  channel_num;
    logic [1:0]  msg_kind;
    logic        press_flag;
    logic        release_flag;
    logic [13:0] raw_value;
  } msg_t;

endpackage

// ===== src/mbsp_in_if.sv =====
interface mbsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== src/mbsp_out_if.sv =====
interface mbsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_status;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [1:0]  msg_length;
  logic [3:0]  channel_num;
  logic [1:0]  msg_kind;
  logic        press_flag;
  logic        release_flag;
  logic [13:0] raw_value;

  modport source (
    output valid, output msg_status, output first_data, output second_data,
    output msg_length, output channel_num, output msg_kind, output press_flag,
    output release_flag, output raw_value, input ready
  );
  modport sink (
    input valid, input msg_status, input first_data, input second_data,
    input msg_length, input channel_num, input msg_kind, input press_flag,
    input release_flag, input raw_value, output ready
  );
endinterface

// ===== src/midi_byte_stream_parser_top.sv =====
// MIDI byte parser with running status: one byte per item in, one message per item out.
// A message is parsed in a single pass of logic into the output register, or into the
// one-entry skid register while the output holds one; the skid keeps input open while a
// result waits. Throughput: one byte per cycle while the skid entry is free.
// Reset (rst_n low, synchronous): leaves sysex, clears running status, data count and
// both output entries; the held first data byte is not reset.
module midi_byte_stream_parser_top (
  input  logic              clk,
  input  logic              rst_n,
  mbsp_in_if.sink           in_ch,
  mbsp_out_if.source        out_ch
);

  // parser state
  logic        in_sysex_r, in_sysex_nxt;
  logic [7:0]  running_status_r, running_status_nxt;
  logic        data_count_r, data_count_nxt;
  logic [6:0]  held_first_r, held_first_nxt;

  // output register and skid entry
  mbsp_pkg::msg_t out_msg_r, out_msg_nxt;
  mbsp_pkg::msg_t skid_msg_r, skid_msg_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           skid_valid_r, skid_valid_nxt;

  logic           accept;
  logic           take;
  logic           emit;
  logic [7:0]     b;
  logic [6:0]     emit_d1, emit_d2;
  mbsp_pkg::msg_t new_msg;

  // Input stays open as long as the skid entry is free.
  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign take        = out_valid_r && out_ch.ready;
  assign b           = in_ch.data_byte;

  // Byte classification and state update.
  always_comb begin
    in_sysex_nxt       = in_sysex_r;
    running_status_nxt = running_status_r;
    data_count_nxt     = data_count_r;
    held_first_nxt     = held_first_r;
    emit               = 1'b0;
    emit_d1            = b[6:0];
    emit_d2            = 7'd0;
    if (accept) begin
      priority if (b >= mbsp_pkg::REALTIME_MIN) begin
        // real-time bytes are consumed without touching anything and produce no message
      end else if (b == mbsp_pkg::SYSEX_START) begin
        in_sysex_nxt = 1'b1;
      end else if (b == mbsp_pkg::SYSEX_END) begin
        in_sysex_nxt = 1'b0;
      end else if (in_sysex_r) begin
        // dropped inside sysex
      end else if (b[7]) begin
        // F1..F6 cancel running status; channel status sets it
        running_status_nxt = (b[7:4] == mbsp_pkg::TYPE_SYSTEM) ? mbsp_pkg::NO_STATUS : b;
        data_count_nxt     = 1'b0;
      end else if (running_status_r == mbsp_pkg::NO_STATUS) begin
        // orphan data byte
      end else if (running_status_r[7:4] == mbsp_pkg::TYPE_PROGRAM ||
                   running_status_r[7:4] == mbsp_pkg::TYPE_PRESSURE) begin
        data_count_nxt = 1'b0;
        emit           = 1'b1;
      end else if (!data_count_r) begin
        held_first_nxt = b[6:0];
        data_count_nxt = 1'b1;
      end else begin
        data_count_nxt = 1'b0;
        emit           = 1'b1;
        emit_d1        = held_first_r;
        emit_d2        = b[6:0];
      end
    end
  end

  // Message decode from running status and the two data bytes.
  always_comb begin
    logic [3:0] mtype;
    logic       press;
    mtype                = running_status_r[7:4];
    press                = 1'b0;
    new_msg.msg_status   = running_status_r;
    new_msg.first_data   = emit_d1;
    new_msg.second_data  = emit_d2;
    new_msg.channel_num  = running_status_r[3:0];
    new_msg.msg_length   = (mtype == mbsp_pkg::TYPE_PROGRAM ||
                            mtype == mbsp_pkg::TYPE_PRESSURE) ?
                           mbsp_pkg::LEN_ONE_DATA : mbsp_pkg::LEN_TWO_DATA;
    new_msg.msg_kind     = mbsp_pkg::KIND_OTHER;
    new_msg.press_flag   = 1'b0;
    new_msg.release_flag = 1'b0;
    new_msg.raw_value    = {7'd0, emit_d2};
    unique case (mtype)
      mbsp_pkg::TYPE_NOTE_OFF, mbsp_pkg::TYPE_NOTE_ON: begin
        press                = (mtype == mbsp_pkg::TYPE_NOTE_ON) && (emit_d2 != 7'd0);
        new_msg.msg_kind     = mbsp_pkg::KIND_NOTE;
        new_msg.press_flag   = press;
        new_msg.release_flag = !press;
      end
      mbsp_pkg::TYPE_CC: begin
        press                = (emit_d2 >= mbsp_pkg::CC_PRESS_MIN);
        new_msg.msg_kind     = mbsp_pkg::KIND_CC;
        new_msg.press_flag   = press;
        new_msg.release_flag = !press;
      end
      mbsp_pkg::TYPE_BEND: begin
        new_msg.msg_kind  = mbsp_pkg::KIND_BEND;
        new_msg.raw_value = {emit_d2, emit_d1};
      end
      default: begin
        // aftertouch, program change, channel pressure: defaults above
      end
    endcase
  end

  // Output register plus skid entry; results leave in arrival order.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_msg_nxt    = out_msg_r;
    skid_msg_nxt   = skid_msg_r;
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_msg_nxt    = skid_msg_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = emit;
        skid_msg_nxt   = new_msg;
      end else begin
        out_valid_nxt = emit;
        out_msg_nxt   = new_msg;
      end
    end else if (emit) begin
      skid_valid_nxt = 1'b1;
      skid_msg_nxt   = new_msg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sysex_r       <= 1'b0;
      running_status_r <= mbsp_pkg::NO_STATUS;
      data_count_r     <= 1'b0;
      out_valid_r      <= 1'b0;
      skid_valid_r     <= 1'b0;
    end else begin
      in_sysex_r       <= in_sysex_nxt;
      running_status_r <= running_status_nxt;
      data_count_r     <= data_count_nxt;
      out_valid_r      <= out_valid_nxt;
      skid_valid_r     <= skid_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    held_first_r <= held_first_nxt;
    out_msg_r    <= out_msg_nxt;
    skid_msg_r   <= skid_msg_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.msg_status   = out_msg_r.msg_status;
  assign out_ch.first_data   = out_msg_r.first_data;
  assign out_ch.second_data  = out_msg_r.second_data;
  assign out_ch.msg_length   = out_msg_r.msg_length;
  assign out_ch.channel_num  = out_msg_r.channel_num;
  assign out_ch.msg_kind     = out_msg_r.msg_kind;
  assign out_ch.press_flag   = out_msg_r.press_flag;
  assign out_ch.release_flag = out_msg_r.release_flag;
  assign out_ch.raw_value    = out_msg_r.raw_value;

endmodule
